@@ src/cfur_pkg.sv @@
// ----------------------------------------------------------------------------
// cfur_pkg
// Shared codes, constants and the CRC-16 byte update for the framed receiver.
// ----------------------------------------------------------------------------
package cfur_pkg;

   typedef enum logic [1:0] {
      CMD_BYTE   = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_REARM  = 2'd2,
      CMD_HOLD   = 2'd3
   } command_type;

   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic        REG_GAP_LIMIT  = 1'b0;
   localparam logic [7:0]  GAP_LIMIT_INIT = 8'd4;
   localparam logic [7:0]  GAP_MAX        = 8'hff;
   localparam logic [15:0] CRC_INIT       = 16'hffff;
   localparam logic [15:0] CRC_POLY       = 16'ha001;
   localparam logic [8:0]  HDR_LEN        = 9'd4;

   function automatic logic [15:0] crc16_feed(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ src/cfur_csr.sv @@
// ----------------------------------------------------------------------------
// cfur_csr
// Register-bus slave holding the inter-byte gap limit.
// ----------------------------------------------------------------------------
module cfur_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [cfur_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [cfur_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [cfur_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [7:0]                        gap_limit
);

   logic [7:0] gap_limit_ff;
   logic [7:0] gap_limit_in;
   logic       wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == cfur_pkg::REG_GAP_LIMIT);
   assign gap_limit_in = wr_hit ? pwdata[7:0] : gap_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff <= cfur_pkg::GAP_LIMIT_INIT;
      end else begin
         gap_limit_ff <= gap_limit_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == cfur_pkg::REG_GAP_LIMIT) begin
         prdata = {{(cfur_pkg::CSR_DATA_W-8){1'b0}}, gap_limit_ff};
      end
   end

   assign gap_limit = gap_limit_ff;

endmodule

@@ src/crc16_framed_uart_receiver_top.sv @@
// ----------------------------------------------------------------------------
// crc16_framed_uart_receiver_top
// Length-framed packet receiver with CRC-16 check and frame-buffer writes.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless a stalled result blocks input: the frame
// state, position counter, gap counter and CRC-16 (one byte per cycle, eight
// unrolled bit steps) update at the accepting edge and the registered result
// appears on the rsp side in the next cycle. A result waiting in the output
// register does not block input while rsp_tready is high.
// ----------------------------------------------------------------------------
module crc16_framed_uart_receiver_top #(
   parameter int RX_BUF_DEPTH = 64,
   localparam int IDX_W       = $clog2(RX_BUF_DEPTH),
   localparam int RSP_W       = 12 + IDX_W,
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // rx_byte
   input  logic [1:0]                        req_tuser,   // command
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], write_valid, write_index, stored_byte, zero pad
   output logic [RSP_TDATA_W-1:0]            rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cfur_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cfur_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cfur_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   typedef enum logic [2:0] {
      ST_HUNT = 3'd0,
      ST_DATA = 3'd1,
      ST_CRCL = 3'd2,
      ST_CRCH = 3'd3,
      ST_GOOD = 3'd4,
      ST_ERR  = 3'd5,
      ST_HOLD = 3'd6,
      ST_UNUSED = 3'd7
   } rx_state_type;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(RX_BUF_DEPTH - 1);

   logic [7:0]       gap_limit;
   rx_state_type     state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [7:0]       gap_ff, gap_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       flen_ff, flen_in;

   logic             rsp_valid_ff;
   rx_state_type     out_status_ff;
   logic             out_wvalid_ff, out_wvalid_in;
   logic [IDX_W-1:0] out_index_ff, out_index_in;
   logic [7:0]       out_byte_ff, out_byte_in;

   cfur_pkg::command_type cmd;
   logic             accept;
   logic [IDX_W-1:0] pos;
   logic [IDX_W-1:0] count_inc;
   logic [7:0]       flen_eff;
   logic [7:0]       rx_byte;

   cfur_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .gap_limit (gap_limit)
   );

   assign cmd        = cfur_pkg::command_type'(req_tuser);
   assign rx_byte    = req_tdata;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign pos       = (gap_ff > gap_limit) ? '0 : count_ff;
   assign count_inc = (pos == LAST_POS) ? '0 : pos + 1'b1;
   assign flen_eff  = (pos == IDX_W'(3)) ? rx_byte : flen_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      gap_in        = gap_ff;
      crc_in        = crc_ff;
      flen_in       = flen_ff;
      out_wvalid_in = 1'b0;
      out_index_in  = '0;
      out_byte_in   = '0;
      unique case (cmd)
         cfur_pkg::CMD_TICK: begin
            if (gap_ff != cfur_pkg::GAP_MAX) begin
               gap_in = gap_ff + 8'd1;
            end
         end
         cfur_pkg::CMD_REARM: begin
            state_in = ST_HUNT;
            count_in = '0;
         end
         cfur_pkg::CMD_HOLD: begin
            state_in = ST_HOLD;
         end
         default: begin
            if (state_ff != ST_HOLD) begin
               gap_in        = '0;
               count_in      = count_inc;
               out_wvalid_in = 1'b1;
               out_index_in  = pos;
               out_byte_in   = rx_byte;
               if (pos == IDX_W'(3)) begin
                  flen_in = rx_byte;
               end
               unique case (state_ff)
                  ST_HUNT: begin
                     if (count_inc == IDX_W'(1)) begin
                        crc_in = cfur_pkg::crc16_feed(cfur_pkg::CRC_INIT, rx_byte);
                     end else if (count_inc == IDX_W'(2)) begin
                        crc_in = cfur_pkg::crc16_feed(crc_ff, rx_byte);
                     end else if (count_inc == IDX_W'(3)) begin
                        state_in = ST_DATA;
                        crc_in   = cfur_pkg::crc16_feed(crc_ff, rx_byte);
                     end else begin
                        count_in     = IDX_W'(1);
                        out_index_in = '0;
                        flen_in      = flen_ff;
                        crc_in = cfur_pkg::crc16_feed(cfur_pkg::CRC_INIT, rx_byte);
                     end
                  end
                  ST_DATA: begin
                     if ({1'b0, 8'(count_inc)} == ({1'b0, flen_eff} + cfur_pkg::HDR_LEN))
                     begin
                        state_in = ST_CRCL;
                     end
                     crc_in = cfur_pkg::crc16_feed(crc_ff, rx_byte);
                  end
                  ST_CRCL: begin
                     state_in = (crc_ff[7:0] == rx_byte) ? ST_CRCH : ST_ERR;
                  end
                  ST_CRCH: begin
                     crc_in   = {8'h00, crc_ff[15:8]};
                     state_in = (crc_ff[15:8] == rx_byte) ? ST_GOOD : ST_ERR;
                  end
                  ST_GOOD: begin
                  end
                  default: begin
                     state_in = ST_HUNT;
                     count_in = '0;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         count_ff     <= '0;
         gap_ff       <= '0;
         crc_ff       <= cfur_pkg::CRC_INIT;
         flen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff      <= state_in;
            count_ff      <= count_in;
            gap_ff        <= gap_in;
            crc_ff        <= crc_in;
            flen_ff       <= flen_in;
            rsp_valid_ff  <= 1'b1;
            out_status_ff <= state_in;
            out_wvalid_ff <= out_wvalid_in;
            out_index_ff  <= out_index_in;
            out_byte_ff   <= out_byte_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_byte_ff, out_index_ff, out_wvalid_ff,
                                     out_status_ff});

   // result always follows an accepted beat
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted beat produced no result");

   // a stalled result must not be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while result stalled");

   // hold command lands in hold state
   a_hold_status: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == cfur_pkg::CMD_HOLD) |=> (out_status_ff == ST_HOLD))
      else $error("hold command did not report hold");

   // ticks never decrease the gap counter
   a_tick_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == cfur_pkg::CMD_TICK) |=> (gap_ff >= $past(gap_ff)))
      else $error("gap counter decreased on tick");

   // buffer writes stay inside the buffer
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_wvalid_ff) |-> (out_index_ff <= LAST_POS))
      else $error("write index beyond buffer");

endmodule
